>>> hdl/cdmf_pkg.sv
package cdmf_pkg;

    // fixed geometry and field widths
    localparam int KERNEL_SIZE = 3;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PIX_W       = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = PIX_W + COEF_W;
    localparam int PART_W      = PROD_W + 2;
    localparam int SUM_W       = 40;
    localparam int CIDX_W      = 7;
    localparam int FIDX_W      = 3;
    localparam int OPOS_W      = 6;
    localparam int SIZE_W      = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int MIN_SIZE    = 3;

    // defaults for the top level parameters
    localparam int NUM_FILTERS_DEF = 8;
    localparam int MAX_COLS_DEF    = 64;
    localparam int MAX_ROWS_DEF    = 64;

    localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd28;
    localparam logic [SIZE_W-1:0] COLS_RESET = 7'd28;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b1;

    // input word modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [CIDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [PIX_W-1:0]  pixel;
    } in_word_t;

    typedef struct packed {
        logic [FIDX_W-1:0]       filter_index;
        logic [OPOS_W-1:0]       out_row;
        logic [OPOS_W-1:0]       out_col;
        logic signed [SUM_W-1:0] conv_sum;
        logic                    last;
    } out_word_t;

    typedef struct packed {
        logic coef_wr;
        logic pix_start;
        logic line_upd;
        logic issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic win_done;
        logic issue_last;
        logic pipe_busy;
        logic advance;
    } dp_stat_t;

endpackage

>>> hdl/cdmf_ctrl.sv
module cdmf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_mode,
    output logic                 s_ready,
    input  cdmf_pkg::dp_stat_t   stat,
    output cdmf_pkg::ctrl_cmd_t  cmd
);
    import cdmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LINE  = 3'b010,
        ST_ISSUE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && !stat.pipe_busy;
    assign accept  = s_valid && s_ready;

    assign cmd.coef_wr   = accept && (s_mode == MODE_LOAD);
    assign cmd.pix_start = accept && (s_mode == MODE_PIXEL);
    assign cmd.line_upd  = (state_reg == ST_LINE);
    assign cmd.issue     = (state_reg == ST_ISSUE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.pix_start) state_next = ST_LINE;
            end
            ST_LINE: begin
                state_next = stat.win_done ? ST_ISSUE : ST_IDLE;
            end
            ST_ISSUE: begin
                if (stat.advance && stat.issue_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    a_issue_after_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |->
            ($past(state_reg) == ST_LINE) || ($past(state_reg) == ST_ISSUE))
        else $error("filter sweep entered without a line update");

endmodule

>>> hdl/cdmf_datapath.sv
module cdmf_datapath #(
    parameter int NUM_FILTERS = cdmf_pkg::NUM_FILTERS_DEF,
    parameter int MAX_COLS    = cdmf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = cdmf_pkg::MAX_ROWS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [cdmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdmf_pkg::SIZE_W-1:0]        cfg_data,
    input  cdmf_pkg::in_word_t                 in_word,
    input  cdmf_pkg::ctrl_cmd_t                cmd,
    output cdmf_pkg::dp_stat_t                 stat,
    input  logic                               m_ready,
    output logic                               m_valid,
    output cdmf_pkg::out_word_t                m_data
);
    import cdmf_pkg::*;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CW         = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
    localparam int RW         = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;
    localparam int FILT_W     = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int COEF_DEPTH = NUM_FILTERS * TAPS;

    typedef struct packed {
        logic [FIDX_W-1:0] filter_index;
        logic [OPOS_W-1:0] out_row;
        logic [OPOS_W-1:0] out_col;
        logic              last;
    } tag_t;

    // ---- image size registers ----
    logic [SIZE_W-1:0] rows_reg, rows_next, cols_reg, cols_next;
    logic [CW-1:0]     cols_eff;
    logic [RW-1:0]     rows_eff;

    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_ROWS: rows_next = cfg_data;
                REG_IMAGE_COLS: cols_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end else begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    always_comb begin
        if (CW'(cols_reg) < CW'(MIN_SIZE))      cols_eff = CW'(MIN_SIZE);
        else if (CW'(cols_reg) > CW'(MAX_COLS)) cols_eff = CW'(MAX_COLS);
        else                                    cols_eff = CW'(cols_reg);
        if (RW'(rows_reg) < RW'(MIN_SIZE))      rows_eff = RW'(MIN_SIZE);
        else if (RW'(rows_reg) > RW'(MAX_ROWS)) rows_eff = RW'(MAX_ROWS);
        else                                    rows_eff = RW'(rows_reg);
    end

    // ---- frame position ----
    logic [COL_W-1:0] col_pos_reg, col_pos_next, cur_col_reg;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next, cur_row_reg;
    logic [CW-1:0]    col_inc;
    logic [RW-1:0]    row_inc;

    assign col_inc = CW'(col_pos_reg) + CW'(1);
    assign row_inc = RW'(row_pos_reg) + RW'(1);

    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (cmd.coef_wr) begin
            col_pos_next = '0;
            row_pos_next = '0;
        end else if (cmd.pix_start) begin
            if (col_inc >= cols_eff) begin
                col_pos_next = '0;
                row_pos_next = (row_inc >= rows_eff) ? '0 : ROW_W'(row_inc);
            end else begin
                col_pos_next = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // ---- line store: {row above, row before} per column ----
    logic [2*PIX_W-1:0]      line_mem [MAX_COLS];
    logic [2*PIX_W-1:0]      line_q;
    logic signed [PIX_W-1:0] px_reg;

    always_ff @(posedge aclk) begin
        if (cmd.pix_start) begin
            line_q      <= line_mem[col_pos_reg];
            px_reg      <= in_word.pixel;
            cur_col_reg <= col_pos_reg;
            cur_row_reg <= row_pos_reg;
        end
        if (cmd.line_upd) line_mem[cur_col_reg] <= {line_q[PIX_W-1:0], px_reg};
    end

    // ---- 3x3 window, entry row*3+col, newest column on the right ----
    logic signed [PIX_W-1:0] win_reg [TAPS];
    logic signed [PIX_W-1:0] win_in  [KERNEL_SIZE];

    assign win_in[0] = line_q[2*PIX_W-1:PIX_W];
    assign win_in[1] = line_q[PIX_W-1:0];
    assign win_in[2] = px_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TAPS; k++) win_reg[k] <= '0;
        end else if (cmd.line_upd) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                win_reg[i*KERNEL_SIZE]     <= win_reg[i*KERNEL_SIZE + 1];
                win_reg[i*KERNEL_SIZE + 1] <= win_reg[i*KERNEL_SIZE + 2];
                win_reg[i*KERNEL_SIZE + 2] <= win_in[i];
            end
        end
    end

    // ---- coefficient banks, one per tap, addressed by filter ----
    logic [12:0]             idx_scaled;
    logic [3:0]              wr_filt;
    logic [CIDX_W-1:0]       wr_tap;
    logic                    wr_ok;
    logic [FILT_W-1:0]       filt_cnt_reg, filt_cnt_next;
    logic                    advance, issue_go;
    logic signed [COEF_W-1:0] coef_q [TAPS];

    // index / 9 by reciprocal: exact for 7-bit indexes
    assign idx_scaled = 13'(in_word.coef_index) * 13'd57;
    assign wr_filt    = idx_scaled[12:9];
    assign wr_tap     = in_word.coef_index - 7'({3'b000, wr_filt} * 7'd9);
    assign wr_ok      = cmd.coef_wr && (8'(in_word.coef_index) < 8'(COEF_DEPTH));

    assign advance  = !m_valid || m_ready;
    assign issue_go = cmd.issue && advance;

    for (genvar k = 0; k < TAPS; k++) begin : g_bank
        logic signed [COEF_W-1:0] bank [NUM_FILTERS];
        always_ff @(posedge aclk) begin
            if (wr_ok && (wr_tap == CIDX_W'(k))) bank[wr_filt[FILT_W-1:0]] <= in_word.coef_value;
            if (issue_go) coef_q[k] <= bank[filt_cnt_reg];
        end
    end

    always_comb begin
        filt_cnt_next = filt_cnt_reg;
        if (cmd.line_upd)  filt_cnt_next = '0;
        else if (issue_go) filt_cnt_next = filt_cnt_reg + FILT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) filt_cnt_reg <= '0;
        else          filt_cnt_reg <= filt_cnt_next;
    end

    // ---- MAC pipeline: coef read, products, partial sums, output ----
    logic                     v1_reg, v2_reg, v3_reg, out_valid_reg;
    tag_t                     tag1_reg, tag2_reg, tag3_reg;
    tag_t                     tag_next;
    logic signed [PROD_W-1:0] prod_reg [TAPS];
    logic signed [PART_W-1:0] part_reg [KERNEL_SIZE];
    logic signed [SUM_W-1:0]  sum_next;
    out_word_t                out_reg;
    logic [ROW_W-1:0]         row_m2;
    logic [COL_W-1:0]         col_m2;

    assign row_m2 = cur_row_reg - ROW_W'(2);
    assign col_m2 = cur_col_reg - COL_W'(2);

    always_comb begin
        tag_next.filter_index = FIDX_W'(filt_cnt_reg);
        tag_next.out_row      = OPOS_W'(row_m2);
        tag_next.out_col      = OPOS_W'(col_m2);
        tag_next.last         = stat.issue_last;
    end

    assign sum_next = SUM_W'(part_reg[0]) + SUM_W'(part_reg[1]) + SUM_W'(part_reg[2]);

    always_ff @(posedge aclk) begin
        if (advance) begin
            tag1_reg <= tag_next;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            for (int k = 0; k < TAPS; k++) prod_reg[k] <= win_reg[k] * coef_q[k];
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                part_reg[i] <= PART_W'(prod_reg[i*KERNEL_SIZE])
                             + PART_W'(prod_reg[i*KERNEL_SIZE + 1])
                             + PART_W'(prod_reg[i*KERNEL_SIZE + 2]);
            end
            out_reg.filter_index <= tag3_reg.filter_index;
            out_reg.out_row      <= tag3_reg.out_row;
            out_reg.out_col      <= tag3_reg.out_col;
            out_reg.last         <= tag3_reg.last;
            out_reg.conv_sum     <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign stat.win_done   = (cur_row_reg >= ROW_W'(2)) && (cur_col_reg >= COL_W'(2));
    assign stat.issue_last = (filt_cnt_reg == FILT_W'(NUM_FILTERS - 1));
    assign stat.pipe_busy  = v1_reg;
    assign stat.advance    = advance;

    a_window_held: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.line_upd |-> !v1_reg)
        else $error("window shifted while products still pending");

    a_coef_held: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.coef_wr |-> !v1_reg && !cmd.issue)
        else $error("coefficient written during a filter sweep");

    a_stage_from_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v1_reg) |-> $past(cmd.issue))
        else $error("coefficient stage valid without an issue");

    a_last_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.last) |->
            (out_reg.filter_index == FIDX_W'(NUM_FILTERS - 1)))
        else $error("last flag on a filter other than the final one");

endmodule

>>> hdl/conv2d_valid_multi_filter.sv
// channel   dir  handshake            word
// s_        in   s_valid / s_ready    in_word_t  (coef load or raster pixel)
// m_        out  m_valid / m_ready    out_word_t (one sum per filter)
// cfg_      in   cfg_we               cfg_index, cfg_data (image rows, cols)
//
// Coefficient load: taken in idle. Pixel that completes no window: a line update.
// Pixel that completes a window: a line update, then one filter issued per cycle
// (while m_ready does not stall) into the shared nine-multiplier MAC pipeline.
// Synchronous active-low reset clears control, position and window, and sets
// sizes to 28x28; coefficient and line stores hold garbage until written.
// A stall on m_ready freezes the MAC; s_ready drops while its first stage is full.
module conv2d_valid_multi_filter #(
    parameter int NUM_FILTERS = cdmf_pkg::NUM_FILTERS_DEF,
    parameter int MAX_COLS    = cdmf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = cdmf_pkg::MAX_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cdmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdmf_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cdmf_pkg::in_word_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cdmf_pkg::out_word_t            m_data
);
    import cdmf_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    cdmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cdmf_datapath #(
        .NUM_FILTERS (NUM_FILTERS),
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
